// ===== hdl/dbm_pkg.sv =====
`default_nettype none

package dbm_pkg;

  // Field widths fixed by the interface
  localparam int LEN_W  = 16;
  localparam int TIME_W = 24;

  // Default width of the elapsed tick counters
  localparam int TIME_BITS_DEFAULT = 24;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT       = 2'd3;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0]  DEBOUNCE_LENGTH_RESET = 16'd8;
  localparam logic              ACTIVE_LEVEL_RESET    = 1'b0;
  localparam logic [TIME_W-1:0] LIMIT_RESET           = '0;

  // One sample tick as held in the input register
  typedef struct packed {
    logic pin_level;
    logic ack_rise;
    logic ack_fall;
    logic ack_any;
    logic ack_high_long;
    logic ack_low_long;
    logic ignore_next_rise;
    logic ignore_next_fall;
  } item_t;

  // Level change decided by the debouncer for the current tick
  typedef struct packed {
    logic rise;
    logic fall;
    logic level;
  } edge_t;

  // One result item
  typedef struct packed {
    logic              debounced_level;
    logic              rise_flag;
    logic              fall_flag;
    logic              edge_flag;
    logic              high_long;
    logic              low_long;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/dbm_debounce.sv =====
`default_nettype none

module dbm_debounce
  import dbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             pin_level,
  input  wire logic             active_level,
  input  wire logic [LEN_W-1:0] debounce_length,
  output edge_t                 edge_info
);

  logic [LEN_W-1:0] integrator;
  logic [LEN_W-1:0] integrator_next;
  logic             level;
  logic [LEN_W-1:0] len;

  // A length of zero behaves as a length of one.
  assign len = (debounce_length == '0) ? LEN_W'(1) : debounce_length;

  always_comb begin
    integrator_next = integrator;
    if (pin_level == active_level) begin
      if (integrator < len) integrator_next = integrator + LEN_W'(1);
    end else begin
      if (integrator != '0) integrator_next = integrator - LEN_W'(1);
    end
  end

  always_comb begin
    edge_info.rise  = !level && (integrator_next >= len);
    edge_info.fall  = level && (integrator_next == '0);
    edge_info.level = edge_info.rise ? 1'b1 : (edge_info.fall ? 1'b0 : level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      level      <= 1'b0;
    end else if (advance) begin
      integrator <= integrator_next;
      level      <= edge_info.level;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dbm_events.sv =====
`default_nettype none

module dbm_events
  import dbm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire item_t             item,
  input  wire edge_t             edge_info,
  input  wire logic [TIME_W-1:0] high_limit,
  input  wire logic [TIME_W-1:0] low_limit,
  output result_t                result
);

  // Common width for comparing counters against the 24-bit fields
  localparam int CW = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CW-1:0] FIELD_MAX = CW'({TIME_W{1'b1}});

  logic rise_pending, fall_pending, edge_pending;
  logic skip_rise, skip_fall, high_armed, low_armed;
  logic [TIME_BITS-1:0] high_elapsed, low_elapsed;

  logic rise_pending_next, fall_pending_next, edge_pending_next;
  logic skip_rise_next, skip_fall_next, high_armed_next, low_armed_next;
  logic [TIME_BITS-1:0] high_elapsed_next, low_elapsed_next;
  logic [CW-1:0] high_ext, low_ext;
  logic hl, ll;

  always_comb begin
    rise_pending_next = rise_pending;
    fall_pending_next = fall_pending;
    edge_pending_next = edge_pending;
    skip_rise_next    = skip_rise | item.ignore_next_rise;
    skip_fall_next    = skip_fall | item.ignore_next_fall;
    high_armed_next   = high_armed;
    low_armed_next    = low_armed;
    high_elapsed_next = high_elapsed;
    low_elapsed_next  = low_elapsed;

    if (edge_info.rise) begin
      if (skip_rise_next) skip_rise_next = 1'b0;
      else rise_pending_next = 1'b1;
      edge_pending_next = 1'b1;
      high_elapsed_next = '0;
      high_armed_next   = 1'b1;
      low_armed_next    = 1'b0;
    end else if (edge_info.fall) begin
      if (skip_fall_next) skip_fall_next = 1'b0;
      else fall_pending_next = 1'b1;
      edge_pending_next = 1'b1;
      low_elapsed_next  = '0;
      low_armed_next    = 1'b1;
      high_armed_next   = 1'b0;
    end else if (edge_info.level) begin
      if (high_elapsed != TIME_MAX) high_elapsed_next = high_elapsed + TIME_BITS'(1);
    end else begin
      if (low_elapsed != TIME_MAX) low_elapsed_next = low_elapsed + TIME_BITS'(1);
    end
  end

  assign high_ext = CW'(high_elapsed_next);
  assign low_ext  = CW'(low_elapsed_next);

  assign hl = high_armed_next && edge_info.level && (high_ext >= CW'(high_limit));
  assign ll = low_armed_next && !edge_info.level && (low_ext >= CW'(low_limit));

  always_comb begin
    result.debounced_level = edge_info.level;
    result.rise_flag       = rise_pending_next && !skip_rise_next;
    result.fall_flag       = fall_pending_next && !skip_fall_next;
    result.edge_flag       = edge_pending_next;
    result.high_long       = hl;
    result.low_long        = ll;
    result.high_time       = '0;
    result.low_time        = '0;
    if (edge_info.level) begin
      result.high_time = (high_ext > FIELD_MAX) ? {TIME_W{1'b1}} : high_ext[TIME_W-1:0];
    end else begin
      result.low_time = (low_ext > FIELD_MAX) ? {TIME_W{1'b1}} : low_ext[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_pending <= 1'b0;
      fall_pending <= 1'b0;
      edge_pending <= 1'b0;
      skip_rise    <= 1'b0;
      skip_fall    <= 1'b0;
      high_armed   <= 1'b0;
      low_armed    <= 1'b0;
      high_elapsed <= '0;
      low_elapsed  <= '0;
    end else if (advance) begin
      // Acknowledges act after the result of this tick has been formed.
      rise_pending <= rise_pending_next & ~item.ack_rise;
      fall_pending <= fall_pending_next & ~item.ack_fall;
      edge_pending <= edge_pending_next & ~item.ack_any;
      skip_rise    <= skip_rise_next;
      skip_fall    <= skip_fall_next;
      high_armed   <= high_armed_next & ~(item.ack_high_long & hl);
      low_armed    <= low_armed_next & ~(item.ack_low_long & ll);
      high_elapsed <= high_elapsed_next;
      low_elapsed  <= low_elapsed_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/debounce_edge_long_press_monitor.sv =====
// Debounce, edge and long-press monitor.
// Each transfer on the input channel (in_valid, in_stall) is one sample tick:
// the raw pin level plus acknowledge and ignore bits. Each tick yields exactly
// one transfer on the output channel (out_valid, out_stall) carrying the
// debounced level, the sticky edge flags, the long-high and long-low flags
// and the duration in ticks of the current high or low level.
// The tick is captured in an input register; the monitor state is then updated
// and the result register loaded as the tick moves on.
// Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transfer and the
// input register can still take one more tick; in_stall rises only once both
// are occupied. Configuration is written through cfg_we, cfg_index and
// cfg_data; the block relies on the user to do so only while no tick is in
// flight. A synchronous reset clears all monitor state and empties both
// registers; the configuration returns to a debounce length of 8, active
// level 0 and both limits at zero.

`default_nettype none

module debounce_edge_long_press_monitor
  import dbm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]      cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   pin_level,
  input  wire logic                   ack_rise,
  input  wire logic                   ack_fall,
  input  wire logic                   ack_any,
  input  wire logic                   ack_high_long,
  input  wire logic                   ack_low_long,
  input  wire logic                   ignore_next_rise,
  input  wire logic                   ignore_next_fall,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        debounced_level,
  output logic                        rise_flag,
  output logic                        fall_flag,
  output logic                        edge_flag,
  output logic                        high_long,
  output logic                        low_long,
  output logic [TIME_W-1:0]           high_time,
  output logic [TIME_W-1:0]           low_time
);

  // Configuration registers.
  logic [LEN_W-1:0]  debounce_length;
  logic              active_level;
  logic [TIME_W-1:0] high_limit;
  logic [TIME_W-1:0] low_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_length <= DEBOUNCE_LENGTH_RESET;
      active_level    <= ACTIVE_LEVEL_RESET;
      high_limit      <= LIMIT_RESET;
      low_limit       <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_LENGTH: debounce_length <= cfg_data[LEN_W-1:0];
        REG_ACTIVE_LEVEL:    active_level    <= cfg_data[0];
        REG_HIGH_LIMIT:      high_limit      <= cfg_data;
        REG_LOW_LIMIT:       low_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. A tick moves on whenever the result register is free
  // or is being emptied in the same cycle.
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    in_accept;
  result_t result;

  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item.pin_level        <= pin_level;
      item.ack_rise         <= ack_rise;
      item.ack_fall         <= ack_fall;
      item.ack_any          <= ack_any;
      item.ack_high_long    <= ack_high_long;
      item.ack_low_long     <= ack_low_long;
      item.ignore_next_rise <= ignore_next_rise;
      item.ignore_next_fall <= ignore_next_fall;
    end
  end

  // Integrator and debounced level; reports the edge of this tick, if any.
  edge_t edge_info;

  dbm_debounce u_debounce (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .pin_level       (item.pin_level),
    .active_level    (active_level),
    .debounce_length (debounce_length),
    .edge_info       (edge_info)
  );

  // Sticky flags, ignore requests, duration counters and long-press flags.
  dbm_events #(
    .TIME_BITS (TIME_BITS)
  ) u_events (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .edge_info  (edge_info),
    .high_limit (high_limit),
    .low_limit  (low_limit),
    .result     (result)
  );

  // Result register. It holds a stalled transfer until the receiver takes it.
  result_t result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result_q <= result;
  end

  assign debounced_level = result_q.debounced_level;
  assign rise_flag       = result_q.rise_flag;
  assign fall_flag       = result_q.fall_flag;
  assign edge_flag       = result_q.edge_flag;
  assign high_long       = result_q.high_long;
  assign low_long        = result_q.low_long;
  assign high_time       = result_q.high_time;
  assign low_time        = result_q.low_time;

endmodule

`default_nettype wire
